### rtl/core/kpgs_pkg.sv
package kpgs_pkg;

    localparam int INDEX_BITS = 8;
    localparam int IDX_W      = 8;
    localparam int DIM_W      = 9;
    localparam int VEC_W      = 60;
    localparam int COMP_W     = 20;
    localparam int FREQ_W     = 10;
    localparam int PROD_W     = COMP_W + FREQ_W;
    localparam int KC_W       = PROD_W + 2;
    localparam int MAG_W      = 31;
    localparam int K2_W       = 62;
    localparam int COEF_W     = 48;
    localparam int HALF_W     = COEF_W / 2;
    localparam int FP_W       = 36;
    localparam int PP_W       = HALF_W + FP_W;
    localparam int NUM_W      = COEF_W + FP_W;
    localparam int QUO_W      = COEF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VEC_W;

    localparam logic [FP_W-1:0]   FOUR_PI_Q32 = 36'hC90FDAA22;
    localparam logic [COEF_W-1:0] POS_LIMIT   = 48'h7FFF_FFFF_FFFF;
    localparam logic [COEF_W-1:0] NEG_LIMIT   = 48'h8000_0000_0000;
    localparam logic [DIM_W-1:0]  DIM_RESET   = 9'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_VEC_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 3'd5;

    typedef struct packed {
        logic [K2_W-1:0]   rem;
        logic [COEF_W-1:0] low;
        logic [QUO_W-1:0]  quo;
        logic              neg;
        logic              ovf;
    } t_part;

    typedef struct packed {
        logic [K2_W-1:0] k2;
        logic            zero;
        t_part           re;
        t_part           im;
    } t_div;

endpackage

### rtl/core/kpgs_if.sv
interface kpgs_in_if;
    logic                                valid;
    logic                                ready;
    logic [kpgs_pkg::IDX_W-1:0]          idx_x;
    logic [kpgs_pkg::IDX_W-1:0]          idx_y;
    logic [kpgs_pkg::IDX_W-1:0]          idx_z;
    logic signed [kpgs_pkg::COEF_W-1:0]  coef_re;
    logic signed [kpgs_pkg::COEF_W-1:0]  coef_im;
    modport source (output valid, idx_x, idx_y, idx_z, coef_re, coef_im, input ready);
    modport sink (input valid, idx_x, idx_y, idx_z, coef_re, coef_im, output ready);
endinterface

interface kpgs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kpgs_pkg::COEF_W-1:0]  pot_re;
    logic signed [kpgs_pkg::COEF_W-1:0]  pot_im;
    logic                                saturated;
    modport source (output valid, pot_re, pot_im, saturated, input ready);
    modport sink (input valid, pot_re, pot_im, saturated, output ready);
endinterface

interface kpgs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [kpgs_pkg::CFG_IDX_W-1:0]      index;
    logic [kpgs_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/kspace_poisson_green_scale_unit.sv
// an item passes stages 1 to 6, the divider and the output register in order
// throughput: one item per cycle, a stalled output holds the whole pipeline
// cost is set by the 48-stage restoring divider, one quotient bit per stage
// reset (synchronous, active low) clears all valid bits, lattice vectors to 0
// and dimensions to 64
module kspace_poisson_green_scale_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kpgs_in_if.sink    i_in,
    kpgs_cfg_if.sink   i_cfg,
    kpgs_out_if.source o_out
);
    import kpgs_pkg::*;

    localparam int NDIV = QUO_W;

    logic [VEC_W-1:0] r_vec [3];
    logic [DIM_W-1:0] r_dim [3];

    logic en;

    // stage 1
    logic                     r1_v;
    logic signed [FREQ_W-1:0] r1_f [3];
    logic                     r1_zf;
    logic [COEF_W-1:0]        r1_mre, r1_mim;
    logic                     r1_nre, r1_nim;
    // stage 2
    logic                     r2_v;
    logic signed [PROD_W-1:0] r2_p [9];
    logic [PP_W-1:0]          r2_pre_lo, r2_pre_hi, r2_pim_lo, r2_pim_hi;
    logic                     r2_zf, r2_nre, r2_nim;
    // stage 3
    logic                     r3_v;
    logic signed [KC_W-1:0]   r3_c [3];
    logic [NUM_W-1:0]         r3_num_re, r3_num_im;
    logic                     r3_zf, r3_nre, r3_nim;
    // stage 4
    logic                     r4_v;
    logic [MAG_W-1:0]         r4_m [3];
    logic [NUM_W-1:0]         r4_num_re, r4_num_im;
    logic                     r4_zf, r4_nre, r4_nim;
    // stage 5
    logic                     r5_v;
    logic [K2_W-1:0]          r5_sq [3];
    logic [NUM_W-1:0]         r5_num_re, r5_num_im;
    logic                     r5_zf, r5_nre, r5_nim;
    // stage 6
    logic                     r6_v;
    logic [K2_W-1:0]          r6_k2;
    logic [NUM_W-1:0]         r6_num_re, r6_num_im;
    logic                     r6_zf, r6_nre, r6_nim;
    // divider
    logic                     r_dv_v [NDIV+1];
    t_div                     r_dv   [NDIV+1];
    // output
    logic                     r_ov;
    logic [COEF_W-1:0]        r_ore, r_oim;
    logic                     r_osat;

    logic signed [FREQ_W-1:0] n1_f [3];
    logic [IDX_W-1:0]         in_idx [3];
    t_part                    n_re, n_im;
    logic                     n_sat_re, n_sat_im;
    logic [COEF_W-1:0]        n_ore, n_oim;

    function automatic t_part div_step(input t_part p, input logic [K2_W-1:0] k2);
        logic [K2_W:0] t;
        logic          ge;
        t_part         r;
        t          = {p.rem, p.low[COEF_W-1]};
        ge         = t >= {1'b0, k2};
        r          = p;
        r.rem      = ge ? K2_W'(t - {1'b0, k2}) : t[K2_W-1:0];
        r.low      = {p.low[COEF_W-2:0], 1'b0};
        r.quo      = {p.quo[QUO_W-2:0], ge};
        return r;
    endfunction

    function automatic t_part div_init(input logic [NUM_W-1:0] num, input logic neg,
                                       input logic [K2_W-1:0] k2);
        t_part r;
        r.rem = K2_W'(num[NUM_W-1:COEF_W]);
        r.low = num[COEF_W-1:0];
        r.quo = '0;
        r.neg = neg;
        r.ovf = K2_W'(num[NUM_W-1:COEF_W]) >= k2;
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] mag48(input logic [COEF_W-1:0] v);
        return v[COEF_W-1] ? COEF_W'(-v) : v;
    endfunction

    function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v,
                                                      input int i);
        return v[COMP_W*i +: COMP_W];
    endfunction

    assign en          = !r_ov || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    assign in_idx[0] = i_in.idx_x;
    assign in_idx[1] = i_in.idx_y;
    assign in_idx[2] = i_in.idx_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if ({1'b0, in_idx[a][INDEX_BITS-1:0]} < {1'b0, r_dim[a][DIM_W-1:1]}) begin
                n1_f[a] = FREQ_W'(in_idx[a][INDEX_BITS-1:0]);
            end else begin
                n1_f[a] = FREQ_W'({2'b00, in_idx[a][INDEX_BITS-1:0]})
                        - FREQ_W'({1'b0, r_dim[a]});
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_vec[a] <= '0;
                r_dim[a] <= DIM_RESET;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_VEC_A: r_vec[0] <= i_cfg.data;
                CFG_VEC_B: r_vec[1] <= i_cfg.data;
                CFG_VEC_C: r_vec[2] <= i_cfg.data;
                CFG_DIM_X: r_dim[0] <= i_cfg.data[DIM_W-1:0];
                CFG_DIM_Y: r_dim[1] <= i_cfg.data[DIM_W-1:0];
                CFG_DIM_Z: r_dim[2] <= i_cfg.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            for (int j = 0; j <= NDIV; j++) begin
                r_dv_v[j] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v      <= i_in.valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r6_v      <= r5_v;
            r_dv_v[0] <= r6_v;
            for (int j = 0; j < NDIV; j++) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
            r_ov <= r_dv_v[NDIV];
        end
    end

    always_comb begin
        n_re     = r_dv[NDIV].re;
        n_im     = r_dv[NDIV].im;
        n_sat_re = n_re.ovf || (n_re.quo > (n_re.neg ? NEG_LIMIT : POS_LIMIT));
        n_sat_im = n_im.ovf || (n_im.quo > (n_im.neg ? NEG_LIMIT : POS_LIMIT));
        n_ore    = n_sat_re ? (n_re.neg ? NEG_LIMIT : POS_LIMIT) : n_re.quo;
        n_oim    = n_sat_im ? (n_im.neg ? NEG_LIMIT : POS_LIMIT) : n_im.quo;
        if (n_re.neg) begin
            n_ore = COEF_W'(-n_ore);
        end
        if (n_im.neg) begin
            n_oim = COEF_W'(-n_oim);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r1_f[a] <= n1_f[a];
            end
            r1_zf  <= (n1_f[0] == '0) && (n1_f[1] == '0) && (n1_f[2] == '0);
            r1_mre <= mag48(i_in.coef_re);
            r1_mim <= mag48(i_in.coef_im);
            r1_nre <= i_in.coef_re[COEF_W-1];
            r1_nim <= i_in.coef_im[COEF_W-1];

            for (int i = 0; i < 3; i++) begin
                for (int a = 0; a < 3; a++) begin
                    r2_p[3*i+a] <= PROD_W'(comp(r_vec[a], i) * r1_f[a]);
                end
            end
            r2_pre_lo <= PP_W'(r1_mre[HALF_W-1:0] * FOUR_PI_Q32);
            r2_pre_hi <= PP_W'(r1_mre[COEF_W-1:HALF_W] * FOUR_PI_Q32);
            r2_pim_lo <= PP_W'(r1_mim[HALF_W-1:0] * FOUR_PI_Q32);
            r2_pim_hi <= PP_W'(r1_mim[COEF_W-1:HALF_W] * FOUR_PI_Q32);
            r2_zf     <= r1_zf;
            r2_nre    <= r1_nre;
            r2_nim    <= r1_nim;

            for (int i = 0; i < 3; i++) begin
                r3_c[i] <= KC_W'(r2_p[3*i]) + KC_W'(r2_p[3*i+1]) + KC_W'(r2_p[3*i+2]);
            end
            r3_num_re <= (NUM_W'(r2_pre_hi) << HALF_W) + NUM_W'(r2_pre_lo);
            r3_num_im <= (NUM_W'(r2_pim_hi) << HALF_W) + NUM_W'(r2_pim_lo);
            r3_zf     <= r2_zf;
            r3_nre    <= r2_nre;
            r3_nim    <= r2_nim;

            for (int i = 0; i < 3; i++) begin
                r4_m[i] <= r3_c[i][KC_W-1] ? MAG_W'(-r3_c[i]) : MAG_W'(r3_c[i]);
            end
            r4_num_re <= r3_num_re;
            r4_num_im <= r3_num_im;
            r4_zf     <= r3_zf;
            r4_nre    <= r3_nre;
            r4_nim    <= r3_nim;

            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= K2_W'(r4_m[i] * r4_m[i]);
            end
            r5_num_re <= r4_num_re;
            r5_num_im <= r4_num_im;
            r5_zf     <= r4_zf;
            r5_nre    <= r4_nre;
            r5_nim    <= r4_nim;

            r6_k2     <= r5_sq[0] + r5_sq[1] + r5_sq[2];
            r6_num_re <= r5_num_re;
            r6_num_im <= r5_num_im;
            r6_zf     <= r5_zf;
            r6_nre    <= r5_nre;
            r6_nim    <= r5_nim;

            r_dv[0].k2   <= r6_k2;
            r_dv[0].zero <= r6_zf || (r6_k2 == '0);
            r_dv[0].re   <= div_init(r6_num_re, r6_nre, r6_k2);
            r_dv[0].im   <= div_init(r6_num_im, r6_nim, r6_k2);
            for (int j = 0; j < NDIV; j++) begin
                r_dv[j+1].k2   <= r_dv[j].k2;
                r_dv[j+1].zero <= r_dv[j].zero;
                r_dv[j+1].re   <= div_step(r_dv[j].re, r_dv[j].k2);
                r_dv[j+1].im   <= div_step(r_dv[j].im, r_dv[j].k2);
            end

            r_ore  <= r_dv[NDIV].zero ? '0 : n_ore;
            r_oim  <= r_dv[NDIV].zero ? '0 : n_oim;
            r_osat <= !r_dv[NDIV].zero && (n_sat_re || n_sat_im);
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.pot_re    = r_ore;
    assign o_out.pot_im    = r_oim;
    assign o_out.saturated = r_osat;

endmodule

### sim/tb_kspace_poisson_green_scale_unit.sv
`timescale 1ns / 1ps

module tb_kspace_poisson_green_scale_unit;
    import kpgs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 70;
    localparam int RANDOM_ITEMS   = 1430;
    localparam int NUM_PHASES     = 10;

    typedef struct {
        logic [IDX_W-1:0]         idx_x;
        logic [IDX_W-1:0]         idx_y;
        logic [IDX_W-1:0]         idx_z;
        logic signed [COEF_W-1:0] coef_re;
        logic signed [COEF_W-1:0] coef_im;
    } coef_item_t;

    typedef struct {
        logic [COEF_W-1:0] pot_re;
        logic [COEF_W-1:0] pot_im;
        logic              saturated;
    } potential_t;

    typedef struct {
        coef_item_t item;
        bit         typed;
        potential_t pot;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    kpgs_in_if  in_if ();
    kpgs_cfg_if cfg_if ();
    kpgs_out_if out_if ();

    kspace_poisson_green_scale_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_out   (out_if.source)
    );

    // shadow copy of the lattice and grid registers
    logic [VEC_W-1:0] lat_a, lat_b, lat_c;
    logic [DIM_W-1:0] grid_x, grid_y, grid_z;

    potential_t expected_pots[$];
    bit         typed_pending[$];
    potential_t typed_pots[$];

    int  mismatches;
    int  idle_cycles;
    bit  calm;
    int  stall_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint signed signed_freq(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] d);
        if (longint'(idx) < longint'(d >> 1)) begin
            return longint'(idx);
        end
        return longint'(idx) - longint'(d);
    endfunction

    function automatic longint signed lattice_comp(logic [VEC_W-1:0] v, int i);
        logic signed [COMP_W-1:0] c;
        c = v[COMP_W*i +: COMP_W];
        return longint'(c);
    endfunction

    function automatic logic [COEF_W-1:0] green_part(logic signed [COEF_W-1:0] raw,
                                                     logic [63:0] k2, inout logic sat);
        logic [127:0]   mag;
        logic [127:0]   quo;
        logic [127:0]   limit;
        longint signed  r;
        bit             neg;
        r     = longint'(raw);
        neg   = raw[COEF_W-1];
        mag   = neg ? 128'(64'(-r)) : 128'(64'(r));
        quo   = (mag * 128'(FOUR_PI_Q32)) / 128'(k2);
        limit = neg ? 128'(NEG_LIMIT) : 128'(POS_LIMIT);
        if (quo > limit) begin
            quo = limit;
            sat = 1'b1;
        end
        return neg ? COEF_W'(-quo) : COEF_W'(quo);
    endfunction

    function automatic potential_t green_scale(coef_item_t it);
        potential_t          p;
        longint signed       fx, fy, fz, c;
        longint unsigned     k2, m;
        logic                sat;
        p  = '{default: '0};
        fx = signed_freq(it.idx_x, grid_x);
        fy = signed_freq(it.idx_y, grid_y);
        fz = signed_freq(it.idx_z, grid_z);
        if (fx == 0 && fy == 0 && fz == 0) begin
            return p;
        end
        k2 = 0;
        for (int i = 0; i < 3; i++) begin
            c  = lattice_comp(lat_a, i) * fx + lattice_comp(lat_b, i) * fy
               + lattice_comp(lat_c, i) * fz;
            m  = (c < 0) ? longint'(-c) : c;
            k2 = k2 + m * m;
        end
        if (k2 == 0) begin
            return p;
        end
        sat = 1'b0;
        p.pot_re    = green_part(it.coef_re, k2, sat);
        p.pot_im    = green_part(it.coef_im, k2, sat);
        p.saturated = sat;
        return p;
    endfunction

    // transfer bookkeeping, checking and watchdog
    always @(posedge i_clk) begin
        potential_t want;
        bit         typed;
        potential_t tv;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_VEC_A: lat_a  = cfg_if.data[VEC_W-1:0];
                    CFG_VEC_B: lat_b  = cfg_if.data[VEC_W-1:0];
                    CFG_VEC_C: lat_c  = cfg_if.data[VEC_W-1:0];
                    CFG_DIM_X: grid_x = cfg_if.data[DIM_W-1:0];
                    CFG_DIM_Y: grid_y = cfg_if.data[DIM_W-1:0];
                    CFG_DIM_Z: grid_z = cfg_if.data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_pots.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result re=%h im=%h sat=%b",
                                 out_if.pot_re, out_if.pot_im, out_if.saturated);
                    end
                end else begin
                    want  = expected_pots.pop_front();
                    typed = typed_pending.pop_front();
                    tv    = typed_pots.pop_front();
                    if (typed) begin
                        want = tv;
                    end
                    if (out_if.pot_re !== want.pot_re || out_if.pot_im !== want.pot_im ||
                        out_if.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp re=%h im=%h sat=%b got re=%h im=%h sat=%b",
                                     want.pot_re, want.pot_im, want.saturated,
                                     out_if.pot_re, out_if.pot_im, out_if.saturated);
                        end
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                coef_item_t it;
                it.idx_x   = in_if.idx_x;
                it.idx_y   = in_if.idx_y;
                it.idx_z   = in_if.idx_z;
                it.coef_re = in_if.coef_re;
                it.coef_im = in_if.coef_im;
                expected_pots.push_back(green_scale(it));
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // output stalls in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_pots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_coef(coef_item_t it, bit typed, potential_t pot);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_if.valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        in_if.valid   = 1'b1;
        in_if.idx_x   = it.idx_x;
        in_if.idx_y   = it.idx_y;
        in_if.idx_z   = it.idx_z;
        in_if.coef_re = it.coef_re;
        in_if.coef_im = it.coef_im;
        typed_pending.push_back(typed);
        typed_pots.push_back(pot);
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] rand48();
        return COEF_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic signed [COEF_W-1:0] v;
        v = rand48();
        case ($urandom_range(0, 4))
            0: return v;
            1: return v >>> $urandom_range(8, 44);
            2: return v >>> $urandom_range(1, 16);
            3: return $urandom_range(0, 1) ? $signed(POS_LIMIT) : $signed(NEG_LIMIT);
            default: return v >>> $urandom_range(20, 40);
        endcase
    endfunction

    function automatic logic [COMP_W-1:0] rand_comp(int style);
        logic signed [COMP_W-1:0] v;
        v = COMP_W'($urandom());
        case (style)
            0: return v;
            1: return v >>> $urandom_range(2, 8);
            2: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            default: return $urandom_range(0, 3) == 0 ? 20'h0 : v >>> 4;
        endcase
    endfunction

    function automatic logic [VEC_W-1:0] rand_vec(int style);
        return {rand_comp(style), rand_comp(style), rand_comp(style)};
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return 9'd2;
            1: return 9'd256;
            2: return DIM_W'($urandom_range(0, 1));
            3: return 9'd511;
            default: return DIM_W'($urandom_range(2, 256));
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] rand_idx(logic [DIM_W-1:0] d, bit half);
        int top;
        if ($urandom_range(0, 7) == 0 || d < 2) begin
            return IDX_W'($urandom());
        end
        top = half ? d / 2 : d - 1;
        if (top > 255) begin
            top = 255;
        end
        return IDX_W'($urandom_range(0, top));
    endfunction

    stim_row_t directed[20];
    coef_item_t it;
    potential_t none;

    initial begin
        none = '{default: '0};
        // reset lattice is all zero, so every frequency gives zero
        directed[0]  = '{'{8'd0, 8'd0, 8'd0, 48'sd65536, -48'sd65536}, 1, none};
        directed[1]  = '{'{8'd1, 8'd0, 8'd0, $signed(POS_LIMIT), $signed(NEG_LIMIT)}, 1, none};
        directed[2]  = '{'{8'd255, 8'd255, 8'd128, -48'sd1, 48'sd1}, 1, none};
        directed[3]  = '{'{8'd32, 8'd33, 8'd63, 48'sd12345, 48'sd0}, 1, none};
        // from here on unit lattice along each axis, 64 points
        directed[4]  = '{'{8'd0, 8'd0, 8'd0, $signed(POS_LIMIT), $signed(NEG_LIMIT)}, 1, none};
        directed[5]  = '{'{8'd1, 8'd0, 8'd0, 48'sd65536, -48'sd65536}, 1,
                         '{48'h0000000C90FD, 48'hFFFFFFF36F03, 1'b0}};
        directed[6]  = '{'{8'd1, 8'd0, 8'd0, $signed(POS_LIMIT), $signed(NEG_LIMIT)}, 1,
                         '{POS_LIMIT, NEG_LIMIT, 1'b1}};
        directed[7]  = '{'{8'd0, 8'd0, 8'd1, 48'sd0, 48'sd0}, 1, none};
        directed[8]  = '{'{8'd63, 8'd0, 8'd0, 48'sd65536, 48'sd1}, 0, none};
        directed[9]  = '{'{8'd32, 8'd32, 8'd32, -48'sd99999, 48'sd77777}, 0, none};
        directed[10] = '{'{8'd31, 8'd31, 8'd31, 48'sd65536, -48'sd65536}, 0, none};
        directed[11] = '{'{8'd255, 8'd255, 8'd255, $signed(POS_LIMIT), 48'sd5}, 0, none};
        directed[12] = '{'{8'd0, 8'd128, 8'd0, 48'sh0000FFFFFFFF, -48'sd3}, 0, none};
        directed[13] = '{'{8'd64, 8'd65, 8'd100, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA}, 0,
                         none};
        directed[14] = '{'{8'd0, 8'd1, 8'd2, -48'sd1, 48'sd1}, 0, none};
        directed[15] = '{'{8'd7, 8'd200, 8'd128, 48'sh0123_4567_89AB, -48'sh0123_4567_89AB},
                         0, none};
        directed[16] = '{'{8'd170, 8'd85, 8'd127, 48'sd1, 48'sd2}, 0, none};
        directed[17] = '{'{8'd128, 8'd0, 8'd0, -48'sd65536, 48'sd65536}, 0, none};
        directed[18] = '{'{8'd2, 8'd2, 8'd2, 48'sh7000_0000_0000, 48'sh9000_0000_0000}, 0,
                         none};
        directed[19] = '{'{8'd33, 8'd0, 8'd0, 48'sd1000, -48'sd1000}, 0, none};

        mismatches    = 0;
        idle_cycles   = 0;
        stall_left    = 0;
        calm          = 1'b0;
        lat_a         = '0;
        lat_b         = '0;
        lat_c         = '0;
        grid_x        = DIM_RESET;
        grid_y        = DIM_RESET;
        grid_z        = DIM_RESET;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.idx_x   = '0;
        in_if.idx_y   = '0;
        in_if.idx_z   = '0;
        in_if.coef_re = '0;
        in_if.coef_im = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < 20; r++) begin
            if (r == 4) begin
                settle();
                write_reg(CFG_VEC_A, 60'h0000000000_10000);
                write_reg(CFG_VEC_B, 60'h0000010000_00000);
                write_reg(CFG_VEC_C, 60'h1000000000_00000);
            end
            send_coef(directed[r].item, directed[r].typed, directed[r].pot);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            int style;
            settle();
            style = ph % 4;
            if (ph == 1) begin
                write_reg(CFG_VEC_A, {20'h7FFFF, 20'h80000, 20'h7FFFF});
                write_reg(CFG_VEC_B, {20'h80000, 20'h7FFFF, 20'h80000});
                write_reg(CFG_VEC_C, {20'h7FFFF, 20'h7FFFF, 20'h80000});
                write_reg(CFG_DIM_X, 9'd256);
                write_reg(CFG_DIM_Y, 9'd256);
                write_reg(CFG_DIM_Z, 9'd256);
            end else if (ph == 2) begin
                write_reg(CFG_DIM_X, 9'd2);
                write_reg(CFG_DIM_Y, 9'd2);
                write_reg(CFG_DIM_Z, 9'd2);
                write_reg(3'd6, '1);
                write_reg(3'd7, '1);
            end else begin
                write_reg(CFG_VEC_A, rand_vec(style));
                write_reg(CFG_VEC_B, rand_vec(style));
                write_reg(CFG_VEC_C, ph == 5 ? '0 : rand_vec(style));
                write_reg(CFG_DIM_X, rand_dim());
                write_reg(CFG_DIM_Y, rand_dim());
                write_reg(CFG_DIM_Z, rand_dim());
            end
            calm = (ph == NUM_PHASES - 1);
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
                it.idx_x   = rand_idx(grid_x, 0);
                it.idx_y   = rand_idx(grid_y, 0);
                it.idx_z   = rand_idx(grid_z, 1);
                it.coef_re = rand_coef();
                it.coef_im = rand_coef();
                send_coef(it, 0, none);
            end
        end

        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_pots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
